/* src/mtbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_pkg
// Shared types and constants of the track-2 card bit decoder: item layouts,
// decoder state, event and error codes.
// ----------------------------------------------------------------------------
package mtbd_pkg;

  // character limit after reset
  localparam logic [5:0] CHAR_LIMIT_RST = 6'd38;
  // highest character count the index field can carry
  localparam logic [5:0] CHAR_COUNT_MAX = 6'd63;
  // start sentinel, first received bit as bit 0
  localparam logic [4:0] SS_CHAR = 5'h0B;
  // end sentinel character
  localparam logic [4:0] ES_CHAR = 5'h1F;
  // start sentinel data bits seed the longitudinal parity
  localparam logic [3:0] LRC_SEED = 4'hB;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_LRC  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_CHAR    = 3'd2,
    EV_END     = 3'd3,
    EV_SUCCESS = 3'd4,
    EV_ERROR   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ERR_PARITY   = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_LRC      = 2'd2
  } err_t;

  // input item
  typedef struct packed {
    logic bit_value;
    logic restart;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [2:0] event_kind;
    logic [4:0] char_value;
    logic [5:0] char_index;
    logic [4:0] lrc_value;
    logic [1:0] error_cause;
  } out_item_t;

  // decoder state carried from item to item
  typedef struct packed {
    phase_t     phase;
    logic [2:0] ss_progress;
    logic [2:0] bit_pos;
    logic [3:0] word;
    logic       parity;
    logic [3:0] lrc_acc;
    logic [5:0] char_count;
    logic [3:0] lrc_shift;
  } dec_state_t;

  localparam dec_state_t DEC_STATE_RST = '{
    phase:       PH_HUNT,
    ss_progress: 3'd0,
    bit_pos:     3'd0,
    word:        4'd0,
    parity:      1'b1,
    lrc_acc:     LRC_SEED,
    char_count:  6'd0,
    lrc_shift:   4'd0
  };

  localparam out_item_t OUT_NONE = '{
    event_kind:  EV_NONE,
    char_value:  5'd0,
    char_index:  6'd0,
    lrc_value:   5'd0,
    error_cause: ERR_PARITY
  };

endpackage

/* src/mtbd_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_in_stage
// Input register of the decoder: captures one item and holds it until the
// decode step takes it.
// ----------------------------------------------------------------------------
module mtbd_in_stage
  import mtbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     take,
  output logic     item_vld,
  output in_item_t item
);

  logic     vld_r;
  in_item_t data_r;

  // hold while an item sits here and the step cannot take it
  assign in_stall = vld_r && !take;
  assign item_vld = vld_r;
  assign item     = data_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!in_stall) begin
      vld_r <= in_valid;
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

/* src/mtbd_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_step
// Decode step for one card bit: sentinel hunt, character assembly with odd
// parity, longitudinal parity check and the result for that bit.
// ----------------------------------------------------------------------------
module mtbd_step
  import mtbd_pkg::*;
(
  input  in_item_t   item,
  input  dec_state_t st,
  input  logic [5:0] char_limit,
  output dec_state_t st_nxt,
  output out_item_t  res
);

  logic       b;
  logic [1:0] bp;
  logic [4:0] ch;
  logic       lrc_par;

  assign b       = item.bit_value;
  assign bp      = st.bit_pos[1:0];
  assign ch      = {b, st.word};
  assign lrc_par = ~(^st.lrc_acc);

  always_comb begin
    st_nxt = st;
    res    = OUT_NONE;
    if (item.restart) begin
      st_nxt = DEC_STATE_RST;
    end else begin
      case (st.phase)
        // overlapping matcher for 1,1,0,1,0
        PH_HUNT: begin
          case (st.ss_progress)
            3'd0: st_nxt.ss_progress = b ? 3'd1 : 3'd0;
            3'd1: st_nxt.ss_progress = b ? 3'd2 : 3'd0;
            3'd2: st_nxt.ss_progress = b ? 3'd2 : 3'd3;
            3'd3: st_nxt.ss_progress = b ? 3'd4 : 3'd0;
            3'd4: begin
              if (b) begin
                st_nxt.ss_progress = 3'd2;
              end else begin
                st_nxt            = DEC_STATE_RST;
                st_nxt.phase      = PH_DATA;
                st_nxt.char_count = 6'd1;
                res.event_kind    = EV_START;
                res.char_value    = SS_CHAR;
              end
            end
            default: st_nxt.ss_progress = 3'd0;
          endcase
        end

        // data characters
        PH_DATA: begin
          if (st.char_count > char_limit || st.char_count == CHAR_COUNT_MAX) begin
            st_nxt          = DEC_STATE_RST;
            res.event_kind  = EV_ERROR;
            res.char_index  = st.char_count;
            res.error_cause = ERR_OVERFLOW;
          end else if (!st.bit_pos[2]) begin
            st_nxt.lrc_acc[bp] = st.lrc_acc[bp] ^ b;
            st_nxt.parity      = st.parity ^ b;
            st_nxt.word[bp]    = b;
            st_nxt.bit_pos     = st.bit_pos + 3'd1;
          end else if (b != st.parity) begin
            st_nxt          = DEC_STATE_RST;
            res.event_kind  = EV_ERROR;
            res.char_index  = st.char_count;
            res.error_cause = ERR_PARITY;
          end else begin
            st_nxt.char_count = st.char_count + 6'd1;
            st_nxt.word       = 4'd0;
            st_nxt.bit_pos    = 3'd0;
            st_nxt.parity     = 1'b1;
            res.char_value    = ch;
            res.char_index    = st.char_count;
            if (ch == ES_CHAR) begin
              st_nxt.phase   = PH_LRC;
              res.event_kind = EV_END;
            end else begin
              res.event_kind = EV_CHAR;
            end
          end
        end

        // lrc character check
        PH_LRC: begin
          if (!st.bit_pos[2]) begin
            if (st.lrc_acc[bp] != b) begin
              st_nxt          = DEC_STATE_RST;
              res.event_kind  = EV_ERROR;
              res.char_index  = st.char_count;
              res.error_cause = ERR_LRC;
            end else begin
              st_nxt.lrc_shift[bp] = b;
              st_nxt.bit_pos       = st.bit_pos + 3'd1;
            end
          end else if (b != lrc_par) begin
            st_nxt          = DEC_STATE_RST;
            res.event_kind  = EV_ERROR;
            res.char_index  = st.char_count;
            res.error_cause = ERR_LRC;
          end else begin
            st_nxt.phase   = PH_DONE;
            st_nxt.bit_pos = 3'd0;
            res.event_kind = EV_SUCCESS;
            res.char_index = st.char_count;
            res.lrc_value  = {lrc_par, st.lrc_shift};
          end
        end

        // card read complete, bits ignored until restart
        PH_DONE: begin
          st_nxt = st;
        end

        default: begin
          st_nxt = DEC_STATE_RST;
        end
      endcase
    end
  end

endmodule

/* src/magstripe_track_bit_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magstripe_track_bit_decoder
// Track-2 card bit decoder: sentinel hunt, character and LRC checking.
// ----------------------------------------------------------------------------
// Every accepted bit item gives exactly one result item, one per cycle when
// neither side stalls. An item waits in the input register and is decoded in
// a single pass of logic into the result register, from which its result
// leaves when the receiver does not stall; the decoder state is updated in
// the same cycle as the result register, so the next item can follow
// straight away. The result register holds a stalled result while the input
// register still takes one more item.
// cfg_wr_en writes the character limit (reset 38); write it only while no
// item is in flight.
module magstripe_track_bit_decoder
  import mtbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_stall,
  output logic       out_valid,
  output out_item_t  out_data,
  input  logic       out_stall,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  logic       item_vld;
  in_item_t   item;
  logic       take;
  dec_state_t st_r;
  dec_state_t st_nxt;
  out_item_t  res;
  logic       out_vld_r;
  out_item_t  out_data_r;
  logic [5:0] char_limit_r;

  // input register
  mtbd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .take     (take),
    .item_vld (item_vld),
    .item     (item)
  );

  // decode step
  mtbd_step u_step (
    .item       (item),
    .st         (st_r),
    .char_limit (char_limit_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  // an item moves on when the result register is free or draining
  assign take = item_vld && (!out_vld_r || !out_stall);

  // character limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_limit_r <= CHAR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      char_limit_r <= cfg_wr_data;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DEC_STATE_RST;
    end else if (take) begin
      st_r <= st_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* src/mtbd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtbd_checker
// Port-level checks of the card bit decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mtbd_checker
  import mtbd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input in_item_t   in_data,
  input logic       in_stall,
  input logic       out_valid,
  input out_item_t  out_data,
  input logic       out_stall,
  input logic       cfg_wr_en,
  input logic [5:0] cfg_wr_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  // a restart item into an empty output side yields an empty result
  a_restart_none: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.restart && !out_valid ##1 !out_stall |=>
      out_valid && out_data.event_kind == EV_NONE)
    else $error("restart did not give an empty result");

  // error cause only on errors
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind != EV_ERROR |-> out_data.error_cause == ERR_PARITY)
    else $error("error cause set without error");

  // character value only on start, character and end events
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_kind == EV_SUCCESS || out_data.event_kind == EV_ERROR
      || out_data.event_kind == EV_NONE) |-> out_data.char_value == 5'd0)
    else $error("character value on a non-character event");

  // no codes beyond error, lrc value only on success
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.event_kind != 3'd6 && out_data.event_kind != 3'd7
      && (out_data.event_kind == EV_SUCCESS || out_data.lrc_value == 5'd0))
    else $error("bad event code or stray lrc value");

endmodule

bind magstripe_track_bit_decoder mtbd_checker u_mtbd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_data     (in_data),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_data    (out_data),
  .out_stall   (out_stall),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the track-2 card bit decoder. Card swipes are built
// bit by bit (sentinel, characters with odd parity, end sentinel, LRC), some
// clean and some with parity, LRC, length, restart or noise faults. A
// behavioural copy of the decoder predicts one result per accepted bit, and
// each result leaving the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import mtbd_pkg::*;

  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  typedef enum int {
    FLT_NONE,
    FLT_PARITY,
    FLT_LRC_BIT,
    FLT_LRC_PAR,
    FLT_RESTART,
    FLT_NOISE
  } fault_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  in_item_t   in_data;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;
  logic       out_stall = 1'b0;
  logic       cfg_wr_en;
  logic [5:0] cfg_wr_data;

  // decoder model state
  phase_t     trk_phase;
  logic [2:0] trk_ss;
  logic [2:0] trk_bitpos;
  logic [3:0] trk_word;
  logic       trk_parity;
  logic [3:0] trk_lrc_acc;
  logic [5:0] trk_count;
  logic [3:0] trk_lrc_rx;
  logic [5:0] limit_model;

  out_item_t  track_events[$];
  out_item_t  want;

  int error_count    = 0;
  int results_seen   = 0;
  int bits_sent      = 0;
  int swipes_done    = 0;
  int limit_settings = 0;
  int quiet_cycles   = 0;
  bit idle_enable    = 1'b1;
  int hold_req_id    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int burst_left     = 0;

  magstripe_track_bit_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // back to sentinel hunt
  function automatic void clear_track();
    trk_phase   = PH_HUNT;
    trk_ss      = 3'd0;
    trk_bitpos  = 3'd0;
    trk_word    = 4'd0;
    trk_parity  = 1'b1;
    trk_lrc_acc = LRC_SEED;
    trk_count   = 6'd0;
    trk_lrc_rx  = 4'd0;
  endfunction

  function automatic out_item_t track_fault(err_t cause);
    out_item_t r;
    r             = OUT_NONE;
    r.event_kind  = EV_ERROR;
    r.char_index  = trk_count;
    r.error_cause = cause;
    clear_track();
    return r;
  endfunction

  // expected result of one bit item, model state advanced
  function automatic out_item_t decode_bit(in_item_t it);
    out_item_t  r;
    logic       b;
    logic       p;
    logic [4:0] ch;
    r = OUT_NONE;
    b = it.bit_value;
    if (it.restart) begin
      clear_track();
      return r;
    end
    case (trk_phase)
      PH_HUNT: begin
        // overlapping match of 1,1,0,1,0
        case (trk_ss)
          3'd0: trk_ss = b ? 3'd1 : 3'd0;
          3'd1: trk_ss = b ? 3'd2 : 3'd0;
          3'd2: trk_ss = b ? 3'd2 : 3'd3;
          3'd3: trk_ss = b ? 3'd4 : 3'd0;
          3'd4: begin
            if (b) begin
              trk_ss = 3'd2;
            end else begin
              clear_track();
              trk_phase    = PH_DATA;
              trk_count    = 6'd1;
              r.event_kind = EV_START;
              r.char_value = SS_CHAR;
            end
          end
          default: trk_ss = 3'd0;
        endcase
      end
      PH_DATA: begin
        if (trk_count > limit_model || trk_count >= CHAR_COUNT_MAX) begin
          r = track_fault(ERR_OVERFLOW);
        end else if (trk_bitpos < 3'd4) begin
          trk_lrc_acc[trk_bitpos[1:0]] = trk_lrc_acc[trk_bitpos[1:0]] ^ b;
          trk_parity                   = trk_parity ^ b;
          trk_word[trk_bitpos[1:0]]    = b;
          trk_bitpos                   = trk_bitpos + 3'd1;
        end else if (b != trk_parity) begin
          r = track_fault(ERR_PARITY);
        end else begin
          ch           = {b, trk_word};
          r.char_value = ch;
          r.char_index = trk_count;
          trk_count    = trk_count + 6'd1;
          trk_word     = 4'd0;
          trk_bitpos   = 3'd0;
          trk_parity   = 1'b1;
          if (ch == ES_CHAR) begin
            trk_phase    = PH_LRC;
            r.event_kind = EV_END;
          end else begin
            r.event_kind = EV_CHAR;
          end
        end
      end
      PH_LRC: begin
        if (trk_bitpos < 3'd4) begin
          if (trk_lrc_acc[trk_bitpos[1:0]] != b) begin
            r = track_fault(ERR_LRC);
          end else begin
            trk_lrc_rx[trk_bitpos[1:0]] = b;
            trk_bitpos                  = trk_bitpos + 3'd1;
          end
        end else begin
          p = ~^trk_lrc_acc;
          if (b != p) begin
            r = track_fault(ERR_LRC);
          end else begin
            trk_phase    = PH_DONE;
            trk_bitpos   = 3'd0;
            r.event_kind = EV_SUCCESS;
            r.char_index = trk_count;
            r.lrc_value  = {p, trk_lrc_rx};
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk_item(logic b, logic r);
    in_item_t it;
    it.bit_value = b;
    it.restart   = r;
    return it;
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (track_events.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_data);
      end else begin
        want = track_events.pop_front();
        check_field("event_kind", want.event_kind, out_data.event_kind);
        check_field("char_value", want.char_value, out_data.char_value);
        check_field("char_index", want.char_index, out_data.char_index);
        check_field("lrc_value", want.lrc_value, out_data.lrc_value);
        check_field("error_cause", want.error_cause, out_data.error_cause);
      end
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (hold_seen != hold_req_id) begin
      hold_seen <= hold_req_id;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left <= burst_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 11) == 0) begin
      burst_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // offer one bit item and hold it until accepted
  task automatic send_bit(input in_item_t it);
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bits_sent++;
    track_events.push_back(decode_bit(it));
  endtask

  // stop offering and let every expected result drain
  task automatic quiesce();
    in_valid <= 1'b0;
    while (track_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_char_limit(input logic [5:0] v);
    quiesce();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_model = v;
    limit_settings++;
  endtask

  // one card swipe, bits in track order, closed by a restart
  task automatic swipe(input int n_chars, input fault_t flt);
    in_item_t   seq[$];
    logic [3:0] acc;
    logic [3:0] d;
    int         bad;
    int         pos;
    acc = LRC_SEED;
    // leading clocking bits
    repeat ($urandom_range(0, 6))
      seq.push_back(mk_item((flt == FLT_NOISE) ? 1'($urandom_range(0, 1)) : 1'b0, 1'b0));
    for (int i = 0; i < 5; i++) seq.push_back(mk_item(SS_CHAR[i], 1'b0));
    bad = $urandom_range(0, n_chars);
    // data characters then the end sentinel, odd parity each
    for (int c = 0; c <= n_chars; c++) begin
      d   = (c == n_chars) ? ES_CHAR[3:0] : 4'($urandom_range(0, 14));
      acc = acc ^ d;
      for (int i = 0; i < 4; i++) seq.push_back(mk_item(d[i], 1'b0));
      seq.push_back(mk_item((~^d) ^ (flt == FLT_PARITY && c == bad), 1'b0));
    end
    // longitudinal check character
    bad = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++)
      seq.push_back(mk_item(acc[i] ^ (flt == FLT_LRC_BIT && i == bad), 1'b0));
    seq.push_back(mk_item((~^acc) ^ (flt == FLT_LRC_PAR), 1'b0));
    repeat ($urandom_range(0, 3)) seq.push_back(mk_item(1'($urandom_range(0, 1)), 1'b0));
    if (flt == FLT_RESTART) begin
      pos = $urandom_range(0, seq.size() - 1);
      seq.insert(pos, mk_item(1'($urandom_range(0, 1)), 1'b1));
    end
    if (flt == FLT_NOISE) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, seq.size() - 1);
        seq[pos].bit_value = ~seq[pos].bit_value;
      end
    end
    seq.push_back(mk_item(1'($urandom_range(0, 1)), 1'b1));
    foreach (seq[i]) send_bit(seq[i]);
    swipes_done++;
  endtask

  // random length and fault, now and then past the limit
  task automatic random_swipe();
    int     cap;
    int     n;
    int     r;
    fault_t flt;
    // a zero limit overflows on the first data bit whatever the length
    cap = (limit_model > 6'd10) ? 10 : (limit_model == 6'd0) ? 0 : int'(limit_model) - 1;
    if (limit_model <= 6'd12 && $urandom_range(0, 9) == 0)
      n = int'(limit_model) + $urandom_range(0, 2);
    else
      n = $urandom_range(0, cap);
    r = $urandom_range(0, 9);
    case (r)
      5:       flt = FLT_PARITY;
      6:       flt = FLT_LRC_BIT;
      7:       flt = FLT_LRC_PAR;
      8:       flt = FLT_RESTART;
      9:       flt = FLT_NOISE;
      default: flt = FLT_NONE;
    endcase
    swipe(n, flt);
  endtask

  // short clean swipe with overlapping sentinel, then a bit in the done phase
  task automatic test_directed_swipe();
    logic [24:0] pattern;
    pattern = 25'b111011010_00001_11111_00100_1;
    send_bit(mk_item(1'b1, 1'b1));
    for (int i = 24; i >= 0; i--) send_bit(mk_item(pattern[i], 1'b0));
    send_bit(mk_item(1'b0, 1'b1));
  endtask

  // each fault kind once
  task automatic test_fault_cases();
    swipe(1, FLT_PARITY);
    swipe(1, FLT_LRC_BIT);
    swipe(1, FLT_LRC_PAR);
    swipe(1, FLT_RESTART);
    swipe(1, FLT_NOISE);
  endtask

  // character limits of 1 and 63, at and past the bound
  task automatic test_limit_extremes();
    write_char_limit(6'd1);
    swipe(0, FLT_NONE);
    swipe(1, FLT_NONE);
    write_char_limit(6'd63);
    swipe(62, FLT_NONE);
  endtask

  task automatic test_random_swipes();
    logic [5:0] limits [4];
    limits = '{6'd5, 6'd12, 6'd0, 6'd0};
    limits[3] = 6'($urandom_range(1, 63));
    foreach (limits[k]) begin
      write_char_limit(limits[k]);
      random_swipe();
    end
  endtask

  // receiver holds off while bits keep coming, so the input backs up
  task automatic test_receiver_hold();
    write_char_limit(6'd9);
    hold_req_id <= hold_req_id + 1;
    random_swipe();
  endtask

  // final stretch at full rate on both sides
  task automatic test_full_rate();
    idle_enable = 1'b0;
    write_char_limit(CHAR_LIMIT_RST);
    repeat (2) random_swipe();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    limit_model = CHAR_LIMIT_RST;
    clear_track();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_swipe();
    test_fault_cases();
    test_limit_extremes();
    test_random_swipes();
    test_receiver_hold();
    test_full_rate();
    quiesce();

    $display("covered %0d card swipes, %0d bit items, %0d results checked",
             swipes_done, bits_sent, results_seen);
    $display("with %0d character limit writes, faults of every kind and a long output hold",
             limit_settings);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
